// ----- hdl/ata_pkg.sv -----
// ata_pkg: shared types and constants for the accelerometer tilt block.
// No dependencies; imported by all hdl files.
`default_nettype none
package ata_pkg;
	localparam int TblFrac   = 20;
	localparam int CordSteps = 24;
	localparam int AccW      = 28;

	typedef struct packed {
		logic [15:0] x_word;
		logic [15:0] y_word;
		logic [15:0] z_word;
	} ata_in_t;

	typedef struct packed {
		logic signed [11:0] accel_x;
		logic signed [11:0] accel_y;
		logic signed [11:0] accel_z;
		logic signed [15:0] tilt_angle;
		logic               angle_undefined;
	} ata_out_t;

	// side data that rides along the pipe
	typedef struct packed {
		logic               vld;
		logic [11:0]        cx;
		logic [11:0]        cy;
		logic [11:0]        cz;
		logic               zneg;
		logic [1:0]         kind;
	} ata_tag_t;

	localparam logic [1:0] KindCordic = 2'd0;
	localparam logic [1:0] KindZero   = 2'd1;
	localparam logic [1:0] KindNinety = 2'd2;
	localparam logic [1:0] KindUndef  = 2'd3;

	function automatic logic [AccW-1:0] atan_tbl(input logic [4:0] i);
		case (i)
			5'd0: atan_tbl = 28'd47185920;
			5'd1: atan_tbl = 28'd27855475;
			5'd2: atan_tbl = 28'd14718068;
			5'd3: atan_tbl = 28'd7471121;
			5'd4: atan_tbl = 28'd3750058;
			5'd5: atan_tbl = 28'd1876857;
			5'd6: atan_tbl = 28'd938658;
			5'd7: atan_tbl = 28'd469357;
			5'd8: atan_tbl = 28'd234682;
			5'd9: atan_tbl = 28'd117342;
			5'd10: atan_tbl = 28'd58671;
			5'd11: atan_tbl = 28'd29335;
			5'd12: atan_tbl = 28'd14668;
			5'd13: atan_tbl = 28'd7334;
			5'd14: atan_tbl = 28'd3667;
			5'd15: atan_tbl = 28'd1833;
			5'd16: atan_tbl = 28'd917;
			5'd17: atan_tbl = 28'd458;
			5'd18: atan_tbl = 28'd229;
			5'd19: atan_tbl = 28'd115;
			5'd20: atan_tbl = 28'd57;
			5'd21: atan_tbl = 28'd29;
			5'd22: atan_tbl = 28'd14;
			5'd23: atan_tbl = 28'd7;
			default: atan_tbl = '0;
		endcase
	endfunction
endpackage
`default_nettype wire

// ----- hdl/ata_sqrt_cell.sv -----
// ata_sqrt_cell: one bit of a pipelined restoring square root.
// Depends on ata_pkg.
`default_nettype none
module ata_sqrt_cell
	import ata_pkg::*;
#(
	parameter int VW  = 64,
	parameter int RW  = 32,
	parameter int BIT = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [VW-1:0] rem_i,
	input  wire logic [RW-1:0] root_i,
	input  wire ata_tag_t      tag_i,
	output logic      [VW-1:0] rem_o,
	output logic      [RW-1:0] root_o,
	output ata_tag_t           tag_o
);
	// trial = (root << (BIT+1)) + 4^BIT, compare against remaining value
	logic [VW+1:0] trial;
	logic          take;
	assign trial = ((VW+2)'(root_i) << (BIT+1)) + ((VW+2)'(1) << (2*BIT));
	assign take = {2'b0, rem_i} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_o.vld <= 1'b0;
		end else begin
			tag_o <= tag_i;
		end
	end
	always_ff @(posedge clk) begin
		rem_o      <= take ? VW'({2'b0, rem_i} - trial) : rem_i;
		root_o     <= root_i | (take ? (RW'(1) << BIT) : '0);
	end
endmodule
`default_nettype wire

// ----- hdl/ata_cordic_cell.sv -----
// ata_cordic_cell: one vectoring CORDIC micro-rotation, registered.
// Depends on ata_pkg.
`default_nettype none
module ata_cordic_cell
	import ata_pkg::*;
#(
	parameter int W    = 36,
	parameter int STEP = 0
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic signed [W-1:0]    xv_i,
	input  wire logic signed [W-1:0]    yv_i,
	input  wire logic signed [AccW:0]   acc_i,
	input  wire ata_tag_t               tag_i,
	output logic signed      [W-1:0]    xv_o,
	output logic signed      [W-1:0]    yv_o,
	output logic signed      [AccW:0]   acc_o,
	output ata_tag_t                    tag_o
);
	logic signed [W-1:0]    dx, dy;
	logic signed [AccW:0]   ang;
	assign dx  = yv_i >>> STEP;
	assign dy  = xv_i >>> STEP;
	assign ang = $signed({1'b0, atan_tbl(5'(STEP))});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_o.vld <= 1'b0;
		end else begin
			tag_o <= tag_i;
		end
	end
	always_ff @(posedge clk) begin
		if (yv_i > 0) begin
			xv_o  <= xv_i + dx;
			yv_o  <= yv_i - dy;
			acc_o <= acc_i + ang;
		end else begin
			xv_o  <= xv_i - dx;
			yv_o  <= yv_i + dy;
			acc_o <= acc_i - ang;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/accel_tilt_angle_top.sv -----
// accel_tilt_angle_top: top level of the tilt pipeline.
// Depends on ata_pkg, ata_sqrt_cell, ata_cordic_cell.
// Pipeline: one input register, 33 square-root cells (the scaled sum of squares
// is always 65 bits wide), 24 CORDIC cells and one output register that drives
// done. Throughput: one transaction per cycle; busy is held low, the row of
// cells advances every cycle.
// Reset clears only the valid bits; payload registers are not reset.
`default_nettype none
module accel_tilt_angle_top
	import ata_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = 8,
	parameter int SAMPLE_BITS     = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire ata_in_t din,
	output logic     busy,
	output logic     done,
	output ata_out_t dout
);
	localparam int Guard = 32 - SAMPLE_BITS;
	// sumsq << 2*Guard fits in 2*(SAMPLE_BITS)+1+2*Guard bits
	localparam int VW    = 2*SAMPLE_BITS + 1 + 2*Guard;
	localparam int RW    = (VW + 1) / 2;
	localparam int NS    = RW;
	localparam int CW    = 36;
	localparam logic signed [AccW:0] Deg90 = (AccW+1)'(90) <<< TblFrac;

	assign busy = 1'b0;

	// input stage: counts, magnitudes, special cases
	logic signed [SAMPLE_BITS-1:0] sx, sy, sz;
	logic        [SAMPLE_BITS-1:0] ax, ay, az;
	assign sx = din.x_word[15 -: SAMPLE_BITS];
	assign sy = din.y_word[15 -: SAMPLE_BITS];
	assign sz = din.z_word[15 -: SAMPLE_BITS];
	assign ax = sx[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sx) : sx;
	assign ay = sy[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sy) : sy;
	assign az = sz[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sz) : sz;

	logic [2*SAMPLE_BITS:0] sumsq_s1;
	logic [SAMPLE_BITS:0]   zmag_s1;
	ata_tag_t               tag_s1;
	logic [1:0]             kind;
	always_comb begin
		if (sx == 0 && sy == 0 && sz == 0) kind = KindUndef;
		else if (sx == 0 && sy == 0)       kind = KindZero;
		else if (sz == 0)                  kind = KindNinety;
		else                               kind = KindCordic;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1.vld <= 1'b0;
		end else begin
			tag_s1.vld  <= start;
			tag_s1.cx   <= 12'(sx);
			tag_s1.cy   <= 12'(sy);
			tag_s1.cz   <= 12'(sz);
			tag_s1.zneg <= sz[SAMPLE_BITS-1];
			tag_s1.kind <= kind;
		end
	end
	always_ff @(posedge clk) begin
		sumsq_s1    <= (2*SAMPLE_BITS+1)'(ax * ax) + (2*SAMPLE_BITS+1)'(ay * ay);
		zmag_s1     <= {1'b0, az};
	end

	// square-root row, MSB first
	logic [VW-1:0]             rem  [NS+1];
	logic [RW-1:0]             root [NS+1];
	logic [SAMPLE_BITS:0]      zq   [NS+1];
	ata_tag_t                  stag [NS+1];
	assign rem[0]  = VW'(sumsq_s1) << (2*Guard);
	assign root[0] = '0;
	assign zq[0]   = zmag_s1;
	assign stag[0] = tag_s1;
	for (genvar k = 0; k < NS; k++) begin : g_sqrt
		ata_sqrt_cell #(.VW(VW), .RW(RW), .BIT(NS-1-k)) u_cell (
			.clk, .arst_n, .rem_i(rem[k]), .root_i(root[k]), .tag_i(stag[k]),
			.rem_o(rem[k+1]), .root_o(root[k+1]), .tag_o(stag[k+1]));
		always_ff @(posedge clk) zq[k+1] <= zq[k];
	end

	// CORDIC row
	logic signed [CW-1:0] xv [CordSteps+1];
	logic signed [CW-1:0] yv [CordSteps+1];
	logic signed [AccW:0] acc[CordSteps+1];
	ata_tag_t             ctag[CordSteps+1];
	assign xv[0]   = CW'({zq[NS], {Guard{1'b0}}});
	assign yv[0]   = CW'(root[NS]);
	assign acc[0]  = '0;
	assign ctag[0] = stag[NS];
	for (genvar k = 0; k < CordSteps; k++) begin : g_cordic
		ata_cordic_cell #(.W(CW), .STEP(k)) u_cell (
			.clk, .arst_n, .xv_i(xv[k]), .yv_i(yv[k]), .acc_i(acc[k]), .tag_i(ctag[k]),
			.xv_o(xv[k+1]), .yv_o(yv[k+1]), .acc_o(acc[k+1]), .tag_o(ctag[k+1]));
	end

	// clamp, round, sign, saturate
	logic signed [AccW:0] cl;
	logic signed [AccW+1:0] rnd;
	logic signed [AccW+1:0] mag, sgn;
	logic signed [15:0]     ang;
	ata_tag_t               ft;
	assign ft = ctag[CordSteps];
	always_comb begin
		cl = acc[CordSteps];
		if (cl < 0) cl = '0;
		if (cl > Deg90) cl = Deg90;
		if (TblFrac > ANGLE_FRAC_BITS)
			rnd = ($signed({1'b0, cl}) + ((AccW+2)'(1) <<< (TblFrac-ANGLE_FRAC_BITS-1)))
				>>> (TblFrac-ANGLE_FRAC_BITS);
		else
			rnd = $signed({1'b0, cl});
		case (ft.kind) inside
			KindZero, KindUndef: mag = '0;
			KindNinety:          mag = (AccW+2)'(90) <<< ANGLE_FRAC_BITS;
			default:             mag = rnd;
		endcase
		sgn = (ft.kind == KindCordic && ft.zneg) ? -mag : mag;
		if (sgn > 32767)       ang = 16'sd32767;
		else if (sgn < -32768) ang = -16'sd32768;
		else                   ang = 16'(sgn);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= ft.vld;
	end
	always_ff @(posedge clk) begin
		dout.accel_x         <= ft.cx;
		dout.accel_y         <= ft.cy;
		dout.accel_z         <= ft.cz;
		dout.tilt_angle      <= ang;
		dout.angle_undefined <= (ft.kind == KindUndef);
	end

	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && dout.angle_undefined |-> dout.tilt_angle == 0)
		else $error("undefined angle not zero");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		stag[NS].vld |=> ctag[1].vld)
		else $error("item lost between rows");
	a_never_busy: assert property (@(posedge clk) !busy)
		else $error("busy raised");
endmodule
`default_nettype wire
